FILE: rtl/frb_pkg.sv
package frb_pkg;

   typedef enum logic [2:0] {
      OP_PAYLOAD = 3'd0,
      OP_META    = 3'd1,
      OP_CMP     = 3'd2,
      OP_FASTCMP = 3'd3,
      OP_MASK    = 3'd4,
      OP_VERDICT = 3'd5,
      OP_OTHER   = 3'd6
   } op_type;

   typedef enum logic [2:0] {
      CMP_EQ  = 3'd0,
      CMP_NEQ = 3'd1,
      CMP_LT  = 3'd2,
      CMP_LTE = 3'd3,
      CMP_GT  = 3'd4,
      CMP_GTE = 3'd5
   } cmp_kind_type;

   typedef enum logic [2:0] {
      FLD_SADDR     = 3'd0,
      FLD_DADDR     = 3'd1,
      FLD_SPORT     = 3'd2,
      FLD_DPORT     = 3'd3,
      FLD_PROTO     = 3'd4,
      FLD_BOTHPORTS = 3'd5,
      FLD_UNKNOWN   = 3'd7
   } field_type;

   typedef enum logic [2:0] {
      PS_START      = 3'd0,
      PS_NEXT_LOAD  = 3'd1,
      PS_PAYLOAD    = 3'd2,
      PS_META       = 3'd3,
      PS_END        = 3'd4,
      PS_UNEXPECTED = 3'd5
   } parse_state_type;

   localparam logic [1:0] BASE_LINK      = 2'd0;
   localparam logic [1:0] BASE_NETWORK   = 2'd1;
   localparam logic [1:0] BASE_TRANSPORT = 2'd2;

   localparam logic [7:0] OFF_SADDR = 8'd12;
   localparam logic [7:0] OFF_DADDR = 8'd16;
   localparam logic [7:0] OFF_PROTO = 8'd9;
   localparam logic [7:0] OFF_SPORT = 8'd0;
   localparam logic [7:0] OFF_DPORT = 8'd2;
   localparam logic [7:0] LEN_PORT  = 8'd2;
   localparam logic [7:0] LEN_BOTH  = 8'd4;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_ORDER   = 2'd1;
   localparam logic [1:0] STATUS_UNSUPP  = 2'd2;

   typedef struct packed {
      parse_state_type parse_state;
      field_type       selected_field;
      logic            meta_key_ok;
      logic [31:0]     held_mask;
      logic [31:0]     saddr_low;
      logic [31:0]     saddr_high;
      logic [31:0]     daddr_low;
      logic [31:0]     daddr_high;
      logic [15:0]     sport_low;
      logic [15:0]     sport_high;
      logic [15:0]     dport_low;
      logic [15:0]     dport_high;
      logic [7:0]      proto_low;
      logic [7:0]      proto_high;
      logic [63:0]     rule_priority;
      logic [1:0]      fault_code;
   } rule_state_type;

   typedef struct packed {
      op_type       op;
      logic         first;
      logic [63:0]  handle;
      logic [1:0]   header_base;
      logic [7:0]   header_offset;
      logic [7:0]   load_length;
      cmp_kind_type cmp_kind;
      logic [31:0]  compare_value;
      logic [31:0]  mask_word;
      logic         meta_is_l4proto;
   } rule_item_type;

   function automatic rule_state_type cleared_state(input logic [63:0] prio);
      rule_state_type s;
      s.parse_state    = PS_START;
      s.selected_field = FLD_UNKNOWN;
      s.meta_key_ok    = 1'b0;
      s.held_mask      = '0;
      s.saddr_low      = '0;
      s.saddr_high     = '1;
      s.daddr_low      = '0;
      s.daddr_high     = '1;
      s.sport_low      = '0;
      s.sport_high     = '1;
      s.dport_low      = '0;
      s.dport_high     = '1;
      s.proto_low      = '0;
      s.proto_high     = '0;
      s.rule_priority  = prio;
      s.fault_code     = STATUS_OK;
      return s;
   endfunction

endpackage

FILE: rtl/frb_step.sv
// Next rule state for one expression.
module frb_step (
   input  frb_pkg::rule_state_type cur,
   input  frb_pkg::rule_item_type  item,
   output frb_pkg::rule_state_type nxt
);

   frb_pkg::rule_state_type base;
   frb_pkg::field_type      decoded;
   frb_pkg::cmp_kind_type   kind;
   logic                    cmp_en;
   logic                    raise_order;
   logic                    raise_unsupp;
   logic                    lo_wr;
   logic                    hi_wr;
   logic [31:0]             v;
   logic [31:0]             lo_val;
   logic [31:0]             hi_val;
   logic                    prefix;

   always_comb begin
      decoded = frb_pkg::FLD_UNKNOWN;
      if (item.header_base == frb_pkg::BASE_NETWORK) begin
         if (item.header_offset == frb_pkg::OFF_SADDR) begin
            decoded = frb_pkg::FLD_SADDR;
         end else if (item.header_offset == frb_pkg::OFF_DADDR) begin
            decoded = frb_pkg::FLD_DADDR;
         end else if (item.header_offset == frb_pkg::OFF_PROTO) begin
            decoded = frb_pkg::FLD_PROTO;
         end
      end else if (item.header_base == frb_pkg::BASE_TRANSPORT) begin
         if (item.header_offset == frb_pkg::OFF_DPORT) begin
            decoded = frb_pkg::FLD_DPORT;
         end else if (item.header_offset == frb_pkg::OFF_SPORT) begin
            if (item.load_length == frb_pkg::LEN_PORT) begin
               decoded = frb_pkg::FLD_SPORT;
            end else if (item.load_length == frb_pkg::LEN_BOTH) begin
               decoded = frb_pkg::FLD_BOTHPORTS;
            end
         end
      end
   end

   always_comb begin
      base = item.first ? frb_pkg::cleared_state(item.handle) : cur;
      nxt          = base;
      cmp_en       = 1'b0;
      kind         = item.cmp_kind;
      raise_order  = 1'b0;
      raise_unsupp = 1'b0;

      case (base.parse_state)
         frb_pkg::PS_START, frb_pkg::PS_NEXT_LOAD, frb_pkg::PS_PAYLOAD: begin
            if (base.parse_state == frb_pkg::PS_NEXT_LOAD &&
                item.op == frb_pkg::OP_VERDICT) begin
               nxt.parse_state = frb_pkg::PS_END;
            end else if (base.parse_state == frb_pkg::PS_PAYLOAD &&
                         item.op == frb_pkg::OP_CMP) begin
               cmp_en = 1'b1;
            end else if (base.parse_state == frb_pkg::PS_PAYLOAD &&
                         item.op == frb_pkg::OP_FASTCMP) begin
               cmp_en          = 1'b1;
               kind            = frb_pkg::CMP_EQ;
               nxt.parse_state = frb_pkg::PS_NEXT_LOAD;
            end else if (base.parse_state == frb_pkg::PS_PAYLOAD &&
                         item.op == frb_pkg::OP_MASK) begin
               nxt.held_mask = item.mask_word;
            end else if (item.op == frb_pkg::OP_PAYLOAD) begin
               nxt.selected_field = decoded;
               raise_unsupp       = (decoded == frb_pkg::FLD_UNKNOWN);
               nxt.parse_state    = frb_pkg::PS_PAYLOAD;
            end else if (item.op == frb_pkg::OP_META) begin
               nxt.meta_key_ok = item.meta_is_l4proto;
               nxt.parse_state = frb_pkg::PS_META;
            end else begin
               raise_order     = 1'b1;
               nxt.parse_state = frb_pkg::PS_UNEXPECTED;
            end
         end
         frb_pkg::PS_META: begin
            if (item.op == frb_pkg::OP_FASTCMP) begin
               if (base.meta_key_ok) begin
                  nxt.proto_low  = item.compare_value[31:24];
                  nxt.proto_high = item.compare_value[31:24];
               end else begin
                  raise_unsupp = 1'b1;
               end
               nxt.parse_state = frb_pkg::PS_NEXT_LOAD;
            end else begin
               raise_order     = 1'b1;
               nxt.parse_state = frb_pkg::PS_UNEXPECTED;
            end
         end
         default: begin
         end
      endcase

      // first fault wins
      if (base.fault_code == frb_pkg::STATUS_OK) begin
         if (raise_order) begin
            nxt.fault_code = frb_pkg::STATUS_ORDER;
         end else if (raise_unsupp) begin
            nxt.fault_code = frb_pkg::STATUS_UNSUPP;
         end
      end

      // bound update for the selected field
      prefix = (base.selected_field == frb_pkg::FLD_SADDR ||
                base.selected_field == frb_pkg::FLD_DADDR) && base.held_mask != '0;
      case (base.selected_field)
         frb_pkg::FLD_SPORT, frb_pkg::FLD_DPORT: v = {16'd0, item.compare_value[31:16]};
         frb_pkg::FLD_PROTO:                     v = {24'd0, item.compare_value[31:24]};
         default:                                v = item.compare_value;
      endcase
      lo_wr  = 1'b0;
      hi_wr  = 1'b0;
      lo_val = v;
      hi_val = v;
      if (prefix) begin
         lo_wr  = 1'b1;
         hi_wr  = 1'b1;
         lo_val = item.compare_value + 32'd1;
         hi_val = item.compare_value + ~base.held_mask;
      end else begin
         case (kind)
            frb_pkg::CMP_EQ: begin
               lo_wr = 1'b1;
               hi_wr = 1'b1;
            end
            frb_pkg::CMP_LT: begin
               hi_wr  = 1'b1;
               hi_val = v - 32'd1;
            end
            frb_pkg::CMP_LTE: hi_wr = 1'b1;
            frb_pkg::CMP_GT: begin
               lo_wr  = 1'b1;
               lo_val = v + 32'd1;
            end
            frb_pkg::CMP_GTE: lo_wr = 1'b1;
            default: begin
            end
         endcase
      end

      if (cmp_en) begin
         case (base.selected_field)
            frb_pkg::FLD_BOTHPORTS: begin
               nxt.sport_low  = item.compare_value[31:16];
               nxt.sport_high = item.compare_value[31:16];
               nxt.dport_low  = item.compare_value[15:0];
               nxt.dport_high = item.compare_value[15:0];
            end
            frb_pkg::FLD_SADDR: begin
               if (lo_wr) nxt.saddr_low  = lo_val;
               if (hi_wr) nxt.saddr_high = hi_val;
               if (prefix) nxt.held_mask = '0;
            end
            frb_pkg::FLD_DADDR: begin
               if (lo_wr) nxt.daddr_low  = lo_val;
               if (hi_wr) nxt.daddr_high = hi_val;
               if (prefix) nxt.held_mask = '0;
            end
            frb_pkg::FLD_SPORT: begin
               if (lo_wr) nxt.sport_low  = lo_val[15:0];
               if (hi_wr) nxt.sport_high = hi_val[15:0];
            end
            frb_pkg::FLD_DPORT: begin
               if (lo_wr) nxt.dport_low  = lo_val[15:0];
               if (hi_wr) nxt.dport_high = hi_val[15:0];
            end
            frb_pkg::FLD_PROTO: begin
               if (lo_wr) nxt.proto_low  = lo_val[7:0];
               if (hi_wr) nxt.proto_high = hi_val[7:0];
            end
            default: begin
            end
         endcase
      end
   end

endmodule

FILE: rtl/filter_rule_range_builder_core.sv
// A transaction accepted with req_last set shows its result in the next cycle.
// Throughput: one expression per cycle; req_stall is raised only while a result
// sits in the output register and rsp_stall holds it there.
// Reset (synchronous, active high): open address/port ranges, a zero protocol range,
// the parser to its start state, priority and status to zero, no result pending.
module filter_rule_range_builder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_op,
   input  logic        req_first,
   input  logic        req_last,
   input  logic [63:0] req_handle,
   input  logic [1:0]  req_header_base,
   input  logic [7:0]  req_header_offset,
   input  logic [7:0]  req_load_length,
   input  logic [2:0]  req_cmp_kind,
   input  logic [31:0] req_compare_value,
   input  logic [31:0] req_mask_word,
   input  logic        req_meta_is_l4proto,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_saddr_low,
   output logic [31:0] rsp_saddr_high,
   output logic [31:0] rsp_daddr_low,
   output logic [31:0] rsp_daddr_high,
   output logic [15:0] rsp_sport_low,
   output logic [15:0] rsp_sport_high,
   output logic [15:0] rsp_dport_low,
   output logic [15:0] rsp_dport_high,
   output logic [7:0]  rsp_proto_low,
   output logic [7:0]  rsp_proto_high,
   output logic [63:0] rsp_priority_res,
   output logic [1:0]  rsp_status
);

   frb_pkg::rule_state_type state_ff;
   frb_pkg::rule_state_type state_in;
   frb_pkg::rule_state_type box_ff;
   frb_pkg::rule_item_type  item;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic                    accept;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      item.op              = frb_pkg::op_type'(req_op);
      item.first           = req_first;
      item.handle          = req_handle;
      item.header_base     = req_header_base;
      item.header_offset   = req_header_offset;
      item.load_length     = req_load_length;
      item.cmp_kind        = frb_pkg::cmp_kind_type'(req_cmp_kind);
      item.compare_value   = req_compare_value;
      item.mask_word       = req_mask_word;
      item.meta_is_l4proto = req_meta_is_l4proto;
   end

   frb_step u_step (
      .cur  (state_ff),
      .item (item),
      .nxt  (state_in)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (accept && req_last) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= frb_pkg::cleared_state(64'd0);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            state_ff <= state_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_last) begin
         box_ff <= state_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_saddr_low    = box_ff.saddr_low;
   assign rsp_saddr_high   = box_ff.saddr_high;
   assign rsp_daddr_low    = box_ff.daddr_low;
   assign rsp_daddr_high   = box_ff.daddr_high;
   assign rsp_sport_low    = box_ff.sport_low;
   assign rsp_sport_high   = box_ff.sport_high;
   assign rsp_dport_low    = box_ff.dport_low;
   assign rsp_dport_high   = box_ff.dport_high;
   assign rsp_proto_low    = box_ff.proto_low;
   assign rsp_proto_high   = box_ff.proto_high;
   assign rsp_priority_res = box_ff.rule_priority;
   assign rsp_status       = box_ff.fault_code;

endmodule

FILE: rtl/frb_checker.sv
module frb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [2:0]  req_op,
   input logic        req_first,
   input logic        req_last,
   input logic [63:0] req_handle,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_priority_res,
   input logic [1:0]  rsp_status
);

   logic req_xact;

   assign req_xact = req_valid & ~req_stall;

   // a held result stays until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_xact && req_last |=> rsp_valid)
      else $error("last transaction gave no result");

   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty output");

   a_priority: assert property (@(posedge clock) disable iff (reset)
      req_xact && req_first && req_last |=> rsp_priority_res == $past(req_handle))
      else $error("priority not taken from handle");

   // a rule opening with a compare is out of order
   a_order_fault: assert property (@(posedge clock) disable iff (reset)
      req_xact && req_first && req_last && req_op == frb_pkg::OP_CMP
      |=> rsp_status == frb_pkg::STATUS_ORDER)
      else $error("order fault not reported");

endmodule

bind filter_rule_range_builder_core frb_checker u_frb_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_op           (req_op),
   .req_first        (req_first),
   .req_last         (req_last),
   .req_handle       (req_handle),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_priority_res (rsp_priority_res),
   .rsp_status       (rsp_status)
);

FILE: test/filter_rule_range_builder_checker.sv
module filter_rule_range_builder_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [2:0]  req_op,
   input  logic        req_first,
   input  logic        req_last,
   input  logic [63:0] req_handle,
   input  logic [1:0]  req_header_base,
   input  logic [7:0]  req_header_offset,
   input  logic [7:0]  req_load_length,
   input  logic [2:0]  req_cmp_kind,
   input  logic [31:0] req_compare_value,
   input  logic [31:0] req_mask_word,
   input  logic        req_meta_is_l4proto,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_saddr_low,
   input  logic [31:0] rsp_saddr_high,
   input  logic [31:0] rsp_daddr_low,
   input  logic [31:0] rsp_daddr_high,
   input  logic [15:0] rsp_sport_low,
   input  logic [15:0] rsp_sport_high,
   input  logic [15:0] rsp_dport_low,
   input  logic [15:0] rsp_dport_high,
   input  logic [7:0]  rsp_proto_low,
   input  logic [7:0]  rsp_proto_high,
   input  logic [63:0] rsp_priority_res,
   input  logic [1:0]  rsp_status,
   output int          mismatch_count,
   output int          pending_count
);

   typedef struct packed {
      logic [31:0] saddr_low;
      logic [31:0] saddr_high;
      logic [31:0] daddr_low;
      logic [31:0] daddr_high;
      logic [15:0] sport_low;
      logic [15:0] sport_high;
      logic [15:0] dport_low;
      logic [15:0] dport_high;
      logic [7:0]  proto_low;
      logic [7:0]  proto_high;
      logic [63:0] priority_res;
      logic [1:0]  status;
   } range_box_type;

   frb_pkg::rule_state_type rule;
   range_box_type           pending_boxes[$];
   int                      errors = 0;
   int                      outstanding = 0;

   assign mismatch_count = errors;
   assign pending_count  = outstanding;

   function automatic void open_rule(logic [63:0] prio);
      rule.parse_state    = frb_pkg::PS_START;
      rule.selected_field = frb_pkg::FLD_UNKNOWN;
      rule.meta_key_ok    = 1'b0;
      rule.held_mask      = 32'd0;
      rule.saddr_low      = 32'd0;
      rule.saddr_high     = 32'hffff_ffff;
      rule.daddr_low      = 32'd0;
      rule.daddr_high     = 32'hffff_ffff;
      rule.sport_low      = 16'd0;
      rule.sport_high     = 16'hffff;
      rule.dport_low      = 16'd0;
      rule.dport_high     = 16'hffff;
      rule.proto_low      = 8'd0;
      rule.proto_high     = 8'd0;
      rule.rule_priority  = prio;
      rule.fault_code     = frb_pkg::STATUS_OK;
   endfunction

   // only the first fault of a rule is kept
   function automatic void note_fault(logic [1:0] code);
      if (rule.fault_code == frb_pkg::STATUS_OK)
         rule.fault_code = code;
   endfunction

   function automatic frb_pkg::field_type decode_field(logic [1:0] base, logic [7:0] off,
                                                       logic [7:0] len);
      if (base == frb_pkg::BASE_NETWORK) begin
         if (off == frb_pkg::OFF_SADDR) return frb_pkg::FLD_SADDR;
         if (off == frb_pkg::OFF_DADDR) return frb_pkg::FLD_DADDR;
         if (off == frb_pkg::OFF_PROTO) return frb_pkg::FLD_PROTO;
      end else if (base == frb_pkg::BASE_TRANSPORT) begin
         if (off == frb_pkg::OFF_DPORT) return frb_pkg::FLD_DPORT;
         if (off == frb_pkg::OFF_SPORT && len == frb_pkg::LEN_PORT) return frb_pkg::FLD_SPORT;
         if (off == frb_pkg::OFF_SPORT && len == frb_pkg::LEN_BOTH)
            return frb_pkg::FLD_BOTHPORTS;
      end
      return frb_pkg::FLD_UNKNOWN;
   endfunction

   function automatic void write_bound(frb_pkg::field_type f, bit upper, logic [31:0] v);
      case (f)
         frb_pkg::FLD_SADDR: if (upper) rule.saddr_high = v; else rule.saddr_low = v;
         frb_pkg::FLD_DADDR: if (upper) rule.daddr_high = v; else rule.daddr_low = v;
         frb_pkg::FLD_SPORT:
            if (upper) rule.sport_high = v[15:0]; else rule.sport_low = v[15:0];
         frb_pkg::FLD_DPORT:
            if (upper) rule.dport_high = v[15:0]; else rule.dport_low = v[15:0];
         frb_pkg::FLD_PROTO:
            if (upper) rule.proto_high = v[7:0]; else rule.proto_low = v[7:0];
         default: ;
      endcase
   endfunction

   function automatic void narrow_field(logic [2:0] kind, logic [31:0] cv);
      frb_pkg::field_type f;
      logic [31:0]        v;
      f = rule.selected_field;
      if (f == frb_pkg::FLD_BOTHPORTS) begin
         // kind is ignored: both ports pinned to the word halves
         rule.sport_low  = cv[31:16];
         rule.sport_high = cv[31:16];
         rule.dport_low  = cv[15:0];
         rule.dport_high = cv[15:0];
         return;
      end
      if (f == frb_pkg::FLD_UNKNOWN)
         return;
      if ((f == frb_pkg::FLD_SADDR || f == frb_pkg::FLD_DADDR) && rule.held_mask != 32'd0) begin
         write_bound(f, 1'b0, cv + 32'd1);
         write_bound(f, 1'b1, cv + ~rule.held_mask);
         rule.held_mask = 32'd0;
         return;
      end
      v = cv;
      if (f == frb_pkg::FLD_SPORT || f == frb_pkg::FLD_DPORT)
         v = {16'd0, cv[31:16]};
      else if (f == frb_pkg::FLD_PROTO)
         v = {24'd0, cv[31:24]};
      case (kind)
         frb_pkg::CMP_EQ: begin
            write_bound(f, 1'b0, v);
            write_bound(f, 1'b1, v);
         end
         frb_pkg::CMP_LT:  write_bound(f, 1'b1, v - 32'd1);
         frb_pkg::CMP_LTE: write_bound(f, 1'b1, v);
         frb_pkg::CMP_GT:  write_bound(f, 1'b0, v + 32'd1);
         frb_pkg::CMP_GTE: write_bound(f, 1'b0, v);
         default: ;
      endcase
   endfunction

   function automatic void take_load(logic [2:0] op);
      if (op == frb_pkg::OP_PAYLOAD) begin
         rule.selected_field = decode_field(req_header_base, req_header_offset,
                                            req_load_length);
         if (rule.selected_field == frb_pkg::FLD_UNKNOWN)
            note_fault(frb_pkg::STATUS_UNSUPP);
         rule.parse_state = frb_pkg::PS_PAYLOAD;
      end else if (op == frb_pkg::OP_META) begin
         rule.meta_key_ok = req_meta_is_l4proto;
         rule.parse_state = frb_pkg::PS_META;
      end else begin
         note_fault(frb_pkg::STATUS_ORDER);
         rule.parse_state = frb_pkg::PS_UNEXPECTED;
      end
   endfunction

   function automatic void parse_expr();
      logic [2:0]    op;
      range_box_type b;
      op = req_op;
      if (req_first)
         open_rule(req_handle);
      case (rule.parse_state)
         frb_pkg::PS_NEXT_LOAD: begin
            if (op == frb_pkg::OP_VERDICT)
               rule.parse_state = frb_pkg::PS_END;
            else
               take_load(op);
         end
         frb_pkg::PS_START: take_load(op);
         frb_pkg::PS_PAYLOAD: begin
            if (op == frb_pkg::OP_CMP) begin
               narrow_field(req_cmp_kind, req_compare_value);
            end else if (op == frb_pkg::OP_FASTCMP) begin
               narrow_field(frb_pkg::CMP_EQ, req_compare_value);
               rule.parse_state = frb_pkg::PS_NEXT_LOAD;
            end else if (op == frb_pkg::OP_MASK) begin
               rule.held_mask = req_mask_word;
            end else begin
               take_load(op);
            end
         end
         frb_pkg::PS_META: begin
            if (op == frb_pkg::OP_FASTCMP) begin
               if (rule.meta_key_ok) begin
                  rule.proto_low  = req_compare_value[31:24];
                  rule.proto_high = req_compare_value[31:24];
               end else begin
                  note_fault(frb_pkg::STATUS_UNSUPP);
               end
               rule.parse_state = frb_pkg::PS_NEXT_LOAD;
            end else begin
               note_fault(frb_pkg::STATUS_ORDER);
               rule.parse_state = frb_pkg::PS_UNEXPECTED;
            end
         end
         default: ;
      endcase
      if (req_last) begin
         b = '{rule.saddr_low, rule.saddr_high, rule.daddr_low, rule.daddr_high,
               rule.sport_low, rule.sport_high, rule.dport_low, rule.dport_high,
               rule.proto_low, rule.proto_high, rule.rule_priority, rule.fault_code};
         pending_boxes.push_back(b);
         outstanding++;
      end
   endfunction

   function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      range_box_type b;
      if (reset) begin
         open_rule(64'd0);
         pending_boxes.delete();
         outstanding = 0;
      end else begin
         // retire the result first: a transaction accepted now cannot produce it
         if (rsp_valid && !rsp_stall) begin
            if (pending_boxes.size() == 0) begin
               $error("result transaction with no expectation waiting");
               errors++;
            end else begin
               b = pending_boxes.pop_front();
               outstanding--;
               check_field("saddr_low", 64'(b.saddr_low), 64'(rsp_saddr_low));
               check_field("saddr_high", 64'(b.saddr_high), 64'(rsp_saddr_high));
               check_field("daddr_low", 64'(b.daddr_low), 64'(rsp_daddr_low));
               check_field("daddr_high", 64'(b.daddr_high), 64'(rsp_daddr_high));
               check_field("sport_low", 64'(b.sport_low), 64'(rsp_sport_low));
               check_field("sport_high", 64'(b.sport_high), 64'(rsp_sport_high));
               check_field("dport_low", 64'(b.dport_low), 64'(rsp_dport_low));
               check_field("dport_high", 64'(b.dport_high), 64'(rsp_dport_high));
               check_field("proto_low", 64'(b.proto_low), 64'(rsp_proto_low));
               check_field("proto_high", 64'(b.proto_high), 64'(rsp_proto_high));
               check_field("priority_res", b.priority_res, rsp_priority_res);
               check_field("status", 64'(b.status), 64'(rsp_status));
            end
         end
         if (req_valid && !req_stall)
            parse_expr();
      end
   end

endmodule

FILE: test/filter_rule_range_builder_core_test.sv
module filter_rule_range_builder_core_test;

   localparam int QUIET_LIMIT = 4000;
   localparam int HOLD_CYCLES = 300;
   localparam int ITEM_GOAL   = 1450;

   typedef struct {
      logic [2:0]  op;
      logic        first;
      logic        last;
      logic [63:0] handle;
      logic [1:0]  header_base;
      logic [7:0]  header_offset;
      logic [7:0]  load_length;
      logic [2:0]  cmp_kind;
      logic [31:0] compare_value;
      logic [31:0] mask_word;
      logic        meta_is_l4proto;
   } rule_expr_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_op = '0;
   logic        req_first = 1'b0;
   logic        req_last = 1'b0;
   logic [63:0] req_handle = '0;
   logic [1:0]  req_header_base = '0;
   logic [7:0]  req_header_offset = '0;
   logic [7:0]  req_load_length = '0;
   logic [2:0]  req_cmp_kind = '0;
   logic [31:0] req_compare_value = '0;
   logic [31:0] req_mask_word = '0;
   logic        req_meta_is_l4proto = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_saddr_low;
   logic [31:0] rsp_saddr_high;
   logic [31:0] rsp_daddr_low;
   logic [31:0] rsp_daddr_high;
   logic [15:0] rsp_sport_low;
   logic [15:0] rsp_sport_high;
   logic [15:0] rsp_dport_low;
   logic [15:0] rsp_dport_high;
   logic [7:0]  rsp_proto_low;
   logic [7:0]  rsp_proto_high;
   logic [63:0] rsp_priority_res;
   logic [1:0]  rsp_status;
   int          mismatch_count;
   int          pending_count;

   int  sent_items = 0;
   int  quiet_cycles = 0;
   bit  tx_calm = 1'b0;
   bit  rx_calm = 1'b0;
   bit  hold_off_req = 1'b0;
   bit  rule_open = 1'b0;
   bit  rule_broken = 1'b0;

   filter_rule_range_builder_core i_dut (.*);

   filter_rule_range_builder_checker i_checker (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic rule_expr_type pick(logic [2:0] op);
      rule_expr_type e;
      e.op              = op;
      e.first           = 1'b0;
      e.last            = 1'b0;
      e.handle          = {$urandom, $urandom};
      e.header_base     = 2'($urandom);
      e.header_offset   = 8'($urandom);
      e.load_length     = 8'($urandom);
      e.cmp_kind        = 3'($urandom);
      e.compare_value   = $urandom;
      e.mask_word       = $urandom;
      e.meta_is_l4proto = 1'($urandom);
      return e;
   endfunction

   function automatic rule_expr_type payload_of(logic [1:0] base, logic [7:0] off,
                                                logic [7:0] len);
      rule_expr_type e;
      e = pick(frb_pkg::OP_PAYLOAD);
      e.header_base   = base;
      e.header_offset = off;
      e.load_length   = len;
      return e;
   endfunction

   function automatic rule_expr_type compare_of(logic [2:0] op, logic [2:0] kind,
                                                logic [31:0] value);
      rule_expr_type e;
      e = pick(op);
      e.cmp_kind      = kind;
      e.compare_value = value;
      return e;
   endfunction

   function automatic logic [31:0] edgy_word();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   task automatic offer(input rule_expr_type e);
      int gap;
      gap = tx_calm ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_op              <= e.op;
      req_first           <= e.first;
      req_last            <= e.last;
      req_handle          <= e.handle;
      req_header_base     <= e.header_base;
      req_header_offset   <= e.header_offset;
      req_load_length     <= e.load_length;
      req_cmp_kind        <= e.cmp_kind;
      req_compare_value   <= e.compare_value;
      req_mask_word       <= e.mask_word;
      req_meta_is_l4proto <= e.meta_is_l4proto;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_items++;
   endtask

   // the extra edge lets the checker book the last transaction first
   task automatic await_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // opening expression usually carries first; broken rules get a random op now and then
   task automatic offer_in_rule(input rule_expr_type e);
      if (!rule_open) begin
         e.first   = ($urandom_range(0, 19) != 0);
         rule_open = 1'b1;
      end else if (rule_broken && $urandom_range(0, 4) == 0) begin
         e.op = 3'($urandom);
      end
      offer(e);
   endtask

   task automatic send_rule();
      rule_expr_type e;
      int            clauses;
      int            cmps;
      int            prefix;
      int            fld;
      bit            closing;
      clauses     = $urandom_range(1, 4);
      rule_open   = 1'b0;
      rule_broken = ($urandom_range(0, 9) == 0);
      for (int c = 0; c < clauses; c++) begin
         closing = (c == clauses - 1) ? ($urandom_range(0, 19) != 0)
                                      : ($urandom_range(0, 1) == 1);
         if ($urandom_range(0, 4) == 0) begin
            e = pick(frb_pkg::OP_META);
            e.meta_is_l4proto = ($urandom_range(0, 4) != 0);
            offer_in_rule(e);
            offer_in_rule(compare_of(frb_pkg::OP_FASTCMP, 3'($urandom), edgy_word()));
         end else begin
            fld = $urandom_range(0, 6);
            case (fld)
               0: e = payload_of(frb_pkg::BASE_NETWORK, frb_pkg::OFF_SADDR, frb_pkg::LEN_BOTH);
               1: e = payload_of(frb_pkg::BASE_NETWORK, frb_pkg::OFF_DADDR, frb_pkg::LEN_BOTH);
               2: e = payload_of(frb_pkg::BASE_NETWORK, frb_pkg::OFF_PROTO, 8'd1);
               3: e = payload_of(frb_pkg::BASE_TRANSPORT, frb_pkg::OFF_SPORT, frb_pkg::LEN_PORT);
               4: e = payload_of(frb_pkg::BASE_TRANSPORT, frb_pkg::OFF_DPORT, frb_pkg::LEN_PORT);
               5: e = payload_of(frb_pkg::BASE_TRANSPORT, frb_pkg::OFF_SPORT, frb_pkg::LEN_BOTH);
               default: e = pick(frb_pkg::OP_PAYLOAD);
            endcase
            if (fld < 5 && $urandom_range(0, 3) == 0)
               e.load_length = 8'($urandom);
            offer_in_rule(e);
            if (fld < 2 && $urandom_range(0, 1) == 1) begin
               e = pick(frb_pkg::OP_MASK);
               prefix = $urandom_range(0, 32);
               if ($urandom_range(0, 4) != 0)
                  e.mask_word = (prefix == 0) ? 32'd0 : (32'hffff_ffff << (32 - prefix));
               offer_in_rule(e);
            end
            cmps = $urandom_range(0, 2);
            repeat (cmps) offer_in_rule(compare_of(frb_pkg::OP_CMP, 3'($urandom), edgy_word()));
            if (closing)
               offer_in_rule(compare_of(frb_pkg::OP_FASTCMP, 3'($urandom), edgy_word()));
         end
      end
      e = pick(frb_pkg::OP_VERDICT);
      e.last = ($urandom_range(0, 9) != 0);
      offer_in_rule(e);
      // ignored tail after the verdict, sometimes carrying the result
      if (!e.last || $urandom_range(0, 9) == 0) begin
         e = pick(3'($urandom));
         e.last = !e.last || ($urandom_range(0, 1) == 1);
         offer(e);
      end
   endtask

   task automatic send_noise();
      rule_expr_type e;
      repeat ($urandom_range(1, 4)) begin
         e = pick(3'($urandom));
         e.first = ($urandom_range(0, 3) == 0);
         e.last  = ($urandom_range(0, 2) == 0);
         offer(e);
      end
   endtask

   initial begin
      int n;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_off_req) begin
            n            = HOLD_CYCLES;
            hold_off_req = 1'b0;
         end else begin
            if ($urandom_range(0, 19) == 0)
               rx_calm = !rx_calm;
            n = rx_calm ? 0 : $urandom_range(0, 16);
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   initial begin
      rule_expr_type e;
      bit            hold_done;
      hold_done = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // address prefix, wrapping lt/gt, port bounds, meta protocol
      e = payload_of(frb_pkg::BASE_NETWORK, frb_pkg::OFF_SADDR, frb_pkg::LEN_BOTH);
      e.first  = 1'b1;
      e.handle = 64'hffff_ffff_ffff_ffff;
      offer(e);
      e = pick(frb_pkg::OP_MASK);
      e.mask_word = 32'hffff_ff00;
      offer(e);
      offer(compare_of(frb_pkg::OP_CMP, frb_pkg::CMP_EQ, 32'hc0a8_0100));
      offer(payload_of(frb_pkg::BASE_NETWORK, frb_pkg::OFF_DADDR, frb_pkg::LEN_BOTH));
      offer(compare_of(frb_pkg::OP_CMP, frb_pkg::CMP_LT, 32'h0000_0000));
      offer(compare_of(frb_pkg::OP_CMP, frb_pkg::CMP_GT, 32'hffff_ffff));
      offer(payload_of(frb_pkg::BASE_TRANSPORT, frb_pkg::OFF_SPORT, frb_pkg::LEN_PORT));
      offer(compare_of(frb_pkg::OP_CMP, frb_pkg::CMP_GTE, 32'h0050_0000));
      offer(compare_of(frb_pkg::OP_CMP, frb_pkg::CMP_LTE, 32'hffff_0000));
      offer(payload_of(frb_pkg::BASE_TRANSPORT, frb_pkg::OFF_DPORT, frb_pkg::LEN_PORT));
      offer(compare_of(frb_pkg::OP_CMP, frb_pkg::CMP_NEQ, 32'h1234_5678));
      offer(compare_of(frb_pkg::OP_FASTCMP, frb_pkg::CMP_LT, 32'h01bb_1234));
      e = pick(frb_pkg::OP_META);
      e.meta_is_l4proto = 1'b1;
      offer(e);
      offer(compare_of(frb_pkg::OP_FASTCMP, frb_pkg::CMP_EQ, 32'h1100_0000));
      e = pick(frb_pkg::OP_VERDICT);
      e.last = 1'b1;
      offer(e);

      // both ports, protocol payload, unsupported meta key
      e = payload_of(frb_pkg::BASE_TRANSPORT, frb_pkg::OFF_SPORT, frb_pkg::LEN_BOTH);
      e.first  = 1'b1;
      e.handle = 64'd0;
      offer(e);
      offer(compare_of(frb_pkg::OP_CMP, frb_pkg::CMP_GT, 32'h1234_5678));
      offer(payload_of(frb_pkg::BASE_NETWORK, frb_pkg::OFF_PROTO, 8'd1));
      offer(compare_of(frb_pkg::OP_CMP, 3'd7, 32'hffff_ffff));
      offer(compare_of(frb_pkg::OP_FASTCMP, frb_pkg::CMP_EQ, 32'hff00_0000));
      e = pick(frb_pkg::OP_META);
      e.meta_is_l4proto = 1'b0;
      offer(e);
      offer(compare_of(frb_pkg::OP_FASTCMP, frb_pkg::CMP_EQ, 32'h0600_0000));
      e = pick(frb_pkg::OP_VERDICT);
      e.last = 1'b1;
      offer(e);

      // unsupported base, then a verdict out of order
      e = payload_of(2'd3, frb_pkg::OFF_SADDR, frb_pkg::LEN_BOTH);
      e.first = 1'b1;
      offer(e);
      e = compare_of(frb_pkg::OP_CMP, frb_pkg::CMP_EQ, 32'h0a00_0001);
      e.last = 1'b1;
      offer(e);
      e = pick(frb_pkg::OP_VERDICT);
      e.first = 1'b1;
      e.last  = 1'b1;
      offer(e);
      await_drain();

      while (sent_items < ITEM_GOAL) begin
         if (!hold_done && sent_items >= 500) begin
            // receiver holds off while rules keep coming, then the sender waits it out
            hold_done    = 1'b1;
            hold_off_req = 1'b1;
            tx_calm      = 1'b1;
            repeat (6) send_rule();
            await_drain();
         end
         if ($urandom_range(0, 7) == 0)
            tx_calm = !tx_calm;
         case ($urandom_range(0, 19))
            0: send_noise();
            1: begin
               send_rule();
               await_drain();
            end
            default: send_rule();
         endcase
      end
      await_drain();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
